>>> rtl/timer_deadline_queue_defines.svh
// assertion macros for the timer deadline queue
`ifndef TIMER_DEADLINE_QUEUE_DEFINES_SVH
`define TIMER_DEADLINE_QUEUE_DEFINES_SVH

// same-cycle implication
`define TDQ_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDQ_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tdq_pkg.sv
// shared types and constants of the timer deadline queue
`timescale 1ns / 1ps
package tdq_pkg;
	localparam int DEPTH_DEF = 16;
	localparam logic [4:0] LIMIT_MAX = 5'd16;
	localparam logic [47:0] DL_NONE = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_SCHEDULE = 2'd0,
		ACT_CANCEL   = 2'd1,
		ACT_TICK     = 2'd2,
		ACT_EXPIRE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_DUE   = 2'd3
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] delay;
		logic [31:0] cancel_id;
		logic [4:0]  expire_limit;
	} in_t;

	typedef struct packed {
		action_t     kind;
		status_t     status;
		logic [31:0] tmr_id;
		logic [47:0] next_deadline;
		logic        last;
	} out_t;

	// classified command between front and back
	typedef struct packed {
		action_t     action;
		logic [31:0] delay;
		logic [31:0] cancel_id;
		logic [4:0]  limit;
	} cmd_t;
endpackage

>>> rtl/tdq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module tdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/tdq_front.sv
// input side: two-entry command queue, clamps the expire limit
`timescale 1ns / 1ps
module tdq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tdq_pkg::in_t  in_item,
	output logic          full,
	output logic          cmd_valid,
	output tdq_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	tdq_pkg::cmd_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          do_push, do_pop;
	tdq_pkg::cmd_t cls;

	always_comb begin
		cls.action    = in_item.action;
		cls.delay     = in_item.delay;
		cls.cancel_id = in_item.cancel_id;
		if (in_item.expire_limit == 5'd0) begin
			cls.limit = 5'd1;
		end else if (in_item.expire_limit > tdq_pkg::LIMIT_MAX) begin
			cls.limit = tdq_pkg::LIMIT_MAX;
		end else begin
			cls.limit = in_item.expire_limit;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

>>> rtl/tdq_engine.sv
// back side: slot store, sequential scan and command execution
`timescale 1ns / 1ps
module tdq_engine #(
	parameter int DEPTH = tdq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tdq_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_free,
	output logic          res_we,
	output tdq_pkg::out_t res
);
	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_ACT  = 3'b100
	} state_t;

	state_t          state_q;
	tdq_pkg::cmd_t   cmd_q;
	logic [47:0]     dl_q, clk_q;
	logic [31:0]     idc_q;
	logic [DEPTH-1:0] valid_q;
	logic [CNTW-1:0] cnt_q;
	logic            rd_v_s1;
	logic [AW-1:0]   idx_s1;
	logic            best_f_q, free_f_q, match_f_q;
	logic [47:0]     best_dl_q;
	logic [31:0]     best_id_q;
	logic [AW-1:0]   best_idx_q, free_idx_q, match_idx_q;
	logic            pend_q, post_q;
	logic [31:0]     pend_id_q;
	logic [4:0]      n_q;

	logic            re, we;
	logic [AW-1:0]   waddr;
	logic [79:0]     wdata, rdata;
	logic [31:0]     rd_id;
	logic [47:0]     rd_dl;
	logic [48:0]     dl_sum;
	logic [47:0]     nd, nd_sched;
	logic            due, more;

	assign re    = (state_q == S_SCAN) && (cnt_q != CNTW'(DEPTH));
	assign we    = (state_q == S_ACT) && res_free && (cmd_q.action == tdq_pkg::ACT_SCHEDULE)
		&& free_f_q;
	assign waddr = free_idx_q;
	assign wdata = {idc_q, dl_q};
	assign rd_id = rdata[79:48];
	assign rd_dl = rdata[47:0];

	tdq_ram #(.WIDTH(80), .DEPTH(DEPTH)) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rdata)
	);

	assign dl_sum   = {1'b0, clk_q} + {17'd0, cmd.delay};
	assign nd       = best_f_q ? best_dl_q : tdq_pkg::DL_NONE;
	assign nd_sched = (best_f_q && (best_dl_q < dl_q)) ? best_dl_q : dl_q;
	assign due      = best_f_q && (best_dl_q <= clk_q);
	assign more     = due && (n_q < cmd_q.limit);
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;

	always_comb begin
		res_we            = 1'b0;
		res.kind          = cmd_q.action;
		res.status        = tdq_pkg::ST_OK;
		res.tmr_id        = 32'd0;
		res.next_deadline = nd;
		res.last          = 1'b1;
		if ((state_q == S_ACT) && res_free) begin
			unique case (cmd_q.action)
				tdq_pkg::ACT_SCHEDULE: begin
					res_we = 1'b1;
					if (free_f_q) begin
						res.tmr_id        = idc_q;
						res.next_deadline = nd_sched;
					end else begin
						res.status = tdq_pkg::ST_FULL;
					end
				end
				tdq_pkg::ACT_CANCEL: begin
					res.tmr_id = cmd_q.cancel_id;
					if (post_q) begin
						res_we = 1'b1;
					end else if (!match_f_q) begin
						res_we     = 1'b1;
						res.status = tdq_pkg::ST_NOT_FOUND;
					end
				end
				tdq_pkg::ACT_TICK: begin
					res_we = 1'b1;
				end
				tdq_pkg::ACT_EXPIRE: begin
					if (pend_q) begin
						res_we     = 1'b1;
						res.tmr_id = pend_id_q;
						res.last   = !more;
					end else if (!due) begin
						res_we     = 1'b1;
						res.status = tdq_pkg::ST_NOT_DUE;
					end
				end
				default: res_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
			dl_q  <= dl_sum[48] ? tdq_pkg::DL_NONE : dl_sum[47:0];
		end
		idx_s1 <= cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_q       <= 48'd0;
			idc_q       <= 32'd0;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			best_f_q    <= 1'b0;
			free_f_q    <= 1'b0;
			match_f_q   <= 1'b0;
			best_dl_q   <= 48'd0;
			best_id_q   <= 32'd0;
			best_idx_q  <= '0;
			free_idx_q  <= '0;
			match_idx_q <= '0;
			pend_q      <= 1'b0;
			post_q      <= 1'b0;
			pend_id_q   <= 32'd0;
			n_q         <= 5'd0;
		end else begin
			rd_v_s1 <= re;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q   <= S_SCAN;
						cnt_q     <= '0;
						best_f_q  <= 1'b0;
						free_f_q  <= 1'b0;
						match_f_q <= 1'b0;
						pend_q    <= 1'b0;
						post_q    <= 1'b0;
						n_q       <= 5'd0;
					end
				end
				S_SCAN: begin
					if (re) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
					if (rd_v_s1) begin
						if (valid_q[idx_s1]) begin
							if (!best_f_q || (rd_dl < best_dl_q) ||
								((rd_dl == best_dl_q) && (rd_id < best_id_q))) begin
								best_f_q   <= 1'b1;
								best_dl_q  <= rd_dl;
								best_id_q  <= rd_id;
								best_idx_q <= idx_s1;
							end
							if (!match_f_q && (rd_id == cmd_q.cancel_id)) begin
								match_f_q   <= 1'b1;
								match_idx_q <= idx_s1;
							end
						end else if (!free_f_q) begin
							free_f_q   <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end else if (!re) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (res_free) begin
						state_q <= S_IDLE;
						unique case (cmd_q.action)
							tdq_pkg::ACT_SCHEDULE: begin
								if (free_f_q) begin
									valid_q[free_idx_q] <= 1'b1;
									idc_q               <= idc_q + 32'd1;
								end
							end
							tdq_pkg::ACT_CANCEL: begin
								if (!post_q && match_f_q) begin
									valid_q[match_idx_q] <= 1'b0;
									post_q               <= 1'b1;
									state_q              <= S_SCAN;
								end
							end
							tdq_pkg::ACT_TICK: begin
								if (clk_q != tdq_pkg::DL_NONE) begin
									clk_q <= clk_q + 48'd1;
								end
							end
							tdq_pkg::ACT_EXPIRE: begin
								if (more) begin
									valid_q[best_idx_q] <= 1'b0;
									pend_q              <= 1'b1;
									pend_id_q           <= best_id_q;
									n_q                 <= n_q + 5'd1;
									state_q             <= S_SCAN;
								end
							end
							default: state_q <= S_IDLE;
						endcase
						if (state_q == S_ACT) begin
							cnt_q     <= '0;
							best_f_q  <= 1'b0;
							free_f_q  <= 1'b0;
							match_f_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/timer_deadline_queue.sv
// top level of the timer deadline queue
`timescale 1ns / 1ps
// one-shot timer store of DEPTH slots with a millisecond clock. each input
// transfer schedules a timer (deadline = clock + delay, saturating), cancels
// one by id, ticks the clock, or expires due timers earliest deadline first
// (lower id on ties), up to expire_limit results. every result carries the
// earliest deadline still pending after it, all ones when none is pending.
// a two-entry command queue takes input transfers while the back end works,
// and one result register holds the oldest result until it is popped.
// the back end takes a command from the queue in its idle state. each pass
// over the slot memory then reads one slot per cycle through the single read
// port, plus the read latency, and the act state then acts on it. schedule,
// tick, a cancel miss and an expire with nothing due take one pass; a cancel
// hit takes two passes; an expire that emits n timers takes n + 1 passes. the
// back end also waits while the result register is still occupied.
`include "timer_deadline_queue_defines.svh"
module timer_deadline_queue #(
	parameter int DEPTH = tdq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tdq_pkg::in_t  in_item,
	output logic          empty,
	input  logic          pop,
	output tdq_pkg::out_t out_item
);
	// front to back command channel
	logic          cmd_valid, cmd_pop;
	tdq_pkg::cmd_t cmd;

	// result register
	logic          res_v_q, res_free, res_we;
	tdq_pkg::out_t res, res_q;

	tdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tdq_engine #(.DEPTH(DEPTH)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_free  (res_free),
		.res_we    (res_we),
		.res       (res)
	);

	// free when empty or being popped this cycle
	assign res_free = !res_v_q || pop;
	assign empty    = !res_v_q;
	assign out_item = res_q;

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_we) begin
			res_v_q <= 1'b1;
		end else if (pop) begin
			res_v_q <= 1'b0;
		end
	end

	// a new result never overwrites one that is still waiting
	`TDQ_ASSERT_NOW(a_no_overwrite, clk, arst_n, res_we, !res_v_q || pop, "result overwritten")
	// only expiry transfers come in several results
	`TDQ_ASSERT_NOW(a_single_last, clk, arst_n, !empty && (out_item.kind != tdq_pkg::ACT_EXPIRE), out_item.last, "non-expire result without last")
	// store full is only reported for schedule
	`TDQ_ASSERT_NOW(a_full_kind, clk, arst_n, !empty && (out_item.status == tdq_pkg::ST_FULL), out_item.kind == tdq_pkg::ACT_SCHEDULE, "full status on wrong kind")
	// a written result is visible in the next cycle
	`TDQ_ASSERT_NEXT(a_res_visible, clk, arst_n, res_we, !empty, "result lost")
endmodule
